// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/mm_pkg.sv =====
// ---------------------------------------------------------------------------
// mm_pkg
// Shared widths, command codes, register indexes and control types.
// ---------------------------------------------------------------------------
package mm_pkg;

	localparam int CMD_W     = 2;
	localparam int IDX_W     = 4;
	localparam int ELEM_W    = 16;
	localparam int DOT_W     = 35;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 2;
	localparam int PROD_W    = 2 * ELEM_W;

	localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS_A     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLS_B     = 2'd2;

	localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} mm_state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		logic publish;
	} mm_cmd_t;

	typedef struct packed {
		logic in_query;
		logic oor;
		logic k_last;
		logic pipe_busy;
		logic out_free;
	} mm_status_t;

endpackage

// ===== hdl/mm_in_if.sv =====
// ---------------------------------------------------------------------------
// mm_in_if
// Input channel: one command beat (write A, write B or query).
// ---------------------------------------------------------------------------
interface mm_in_if;
	import mm_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         command;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [ELEM_W-1:0] element_value;

	modport source (output valid, command, row_index, col_index, element_value, input ready);
	modport sink (input valid, command, row_index, col_index, element_value, output ready);
endinterface

// ===== hdl/mm_out_if.sv =====
// ---------------------------------------------------------------------------
// mm_out_if
// Output channel: one result beat per query.
// ---------------------------------------------------------------------------
interface mm_out_if;
	import mm_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [DOT_W-1:0] dot_value;
	logic                    range_err;

	modport source (output valid, dot_value, range_err, input ready);
	modport sink (input valid, dot_value, range_err, output ready);
endinterface

// ===== hdl/mm_cfg_if.sv =====
// ---------------------------------------------------------------------------
// mm_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface mm_cfg_if;
	import mm_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/mm_ram.sv =====
// ---------------------------------------------------------------------------
// mm_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== hdl/mm_ctrl.sv =====
// ---------------------------------------------------------------------------
// mm_ctrl
// Sequencer: accept beats, step the inner loop, publish the result.
// ---------------------------------------------------------------------------
module mm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mm_pkg::mm_status_t status,
	output mm_pkg::mm_cmd_t    cmd
);
	import mm_pkg::*;

	mm_state_t state_q;
	mm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && status.in_query) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				if (status.oor || status.k_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!status.pipe_busy && status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd.accept  = 1'b0;
		cmd.issue   = 1'b0;
		cmd.publish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_RUN: begin
				cmd.issue = !status.oor;
			end
			ST_FINISH: begin
				cmd.publish = !status.pipe_busy && status.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end
endmodule

// ===== hdl/mm_datapath.sv =====
// ---------------------------------------------------------------------------
// mm_datapath
// Size registers, element stores, multiply-accumulate and result register.
// ---------------------------------------------------------------------------
module mm_datapath #(
	parameter int MAX_DIM = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [mm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]         cfg_data,
	input  logic [mm_pkg::CMD_W-1:0]         command,
	input  logic [mm_pkg::IDX_W-1:0]         row_index,
	input  logic [mm_pkg::IDX_W-1:0]         col_index,
	input  logic signed [mm_pkg::ELEM_W-1:0] element_value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [mm_pkg::DOT_W-1:0]  dot_value,
	output logic                             range_err,
	input  mm_pkg::mm_cmd_t                  cmd,
	output mm_pkg::mm_status_t               status
);
	import mm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int SZW   = $clog2(MAX_DIM + 1);
	localparam int CW    = (SZW > CFG_W) ? SZW : CFG_W;
	localparam int KW    = $clog2(MAX_DIM);
	localparam int ACCW  = (PROD_W + 1 + KW > DOT_W + 1) ? (PROD_W + 1 + KW) : (DOT_W + 1);

	localparam logic signed [ACCW-1:0] DOT_HI = {{(ACCW-DOT_W+1){1'b0}}, {(DOT_W-1){1'b1}}};
	localparam logic signed [ACCW-1:0] DOT_LO = {{(ACCW-DOT_W+1){1'b1}}, {(DOT_W-1){1'b0}}};

	logic [CFG_W-1:0] rows_a_q;
	logic [CFG_W-1:0] inner_size_q;
	logic [CFG_W-1:0] cols_b_q;
	logic [CW-1:0]    m_eff;
	logic [CW-1:0]    n_eff;
	logic [CW-1:0]    p_eff;

	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;
	logic [KW-1:0]    k_q;
	logic             oor_q;

	logic             a_wr_en;
	logic             b_wr_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    a_rd_addr;
	logic [AW-1:0]    b_rd_addr;
	logic [ELEM_W-1:0] a_rd_data;
	logic [ELEM_W-1:0] b_rd_data;

	logic                     valid_s1;
	logic                     valid_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACCW-1:0]   acc_q;
	logic signed [ACCW-1:0]   acc_sat;
	logic                     out_valid_q;
	logic signed [DOT_W-1:0]  dot_value_q;
	logic                     range_err_q;

	function automatic logic [CW-1:0] eff_size(input logic [CFG_W-1:0] raw);
		logic [CW-1:0] wide;
		wide = CW'(raw);
		if (wide == '0) begin
			return CW'(1);
		end else if (wide > CW'(MAX_DIM)) begin
			return CW'(MAX_DIM);
		end
		return wide;
	endfunction

	assign m_eff = eff_size(rows_a_q);
	assign n_eff = eff_size(inner_size_q);
	assign p_eff = eff_size(cols_b_q);

	// Size registers; the user must write them only while idle; the block itself does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q     <= SIZE_RESET;
			inner_size_q <= SIZE_RESET;
			cols_b_q     <= SIZE_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ROWS_A:     rows_a_q     <= cfg_data;
				REG_INNER_SIZE: inner_size_q <= cfg_data;
				REG_COLS_B:     cols_b_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Drop loads that fall outside the configured shapes.
	assign a_wr_en = cmd.accept && (command == CMD_WRITE_A)
		&& (CW'(row_index) < m_eff) && (CW'(col_index) < n_eff);
	assign b_wr_en = cmd.accept && (command == CMD_WRITE_B)
		&& (CW'(row_index) < n_eff) && (CW'(col_index) < p_eff);
	assign wr_addr = AW'(int'(row_index) * MAX_DIM + int'(col_index));

	assign a_rd_addr = AW'(int'(row_q) * MAX_DIM + int'(k_q));
	assign b_rd_addr = AW'(int'(k_q) * MAX_DIM + int'(col_q));

	mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_a_ram (
		.clk     (clk),
		.wr_en   (a_wr_en),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_en   (cmd.issue),
		.rd_addr (a_rd_addr),
		.rd_data (a_rd_data)
	);

	mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_b_ram (
		.clk     (clk),
		.wr_en   (b_wr_en),
		.wr_addr (wr_addr),
		.wr_data (element_value),
		.rd_en   (cmd.issue),
		.rd_addr (b_rd_addr),
		.rd_data (b_rd_data)
	);

	// Query context and inner-loop index.
	always_ff @(posedge clk) begin
		if (cmd.accept && (command == CMD_QUERY)) begin
			row_q <= row_index;
			col_q <= col_index;
			k_q   <= '0;
		end else if (cmd.issue) begin
			k_q <= k_q + KW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oor_q       <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept && (command == CMD_QUERY)) begin
				oor_q <= (CW'(row_index) >= m_eff) || (CW'(col_index) >= p_eff);
			end
			valid_s1 <= cmd.issue;
			valid_s2 <= valid_s1;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Multiply, then accumulate one stage later.
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			prod_s2 <= $signed(a_rd_data) * $signed(b_rd_data);
		end
		if (cmd.accept && (command == CMD_QUERY)) begin
			acc_q <= '0;
		end else if (valid_s2) begin
			acc_q <= acc_q + {{(ACCW-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	always_comb begin
		if (acc_q > DOT_HI) begin
			acc_sat = DOT_HI;
		end else if (acc_q < DOT_LO) begin
			acc_sat = DOT_LO;
		end else begin
			acc_sat = acc_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			dot_value_q <= oor_q ? '0 : acc_sat[DOT_W-1:0];
			range_err_q <= oor_q;
		end
	end

	assign out_valid = out_valid_q;
	assign dot_value = dot_value_q;
	assign range_err = range_err_q;

	assign status.in_query  = (command == CMD_QUERY);
	assign status.oor       = oor_q;
	assign status.k_last    = (CW'(k_q) == (n_eff - CW'(1)));
	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.out_free  = !out_valid_q || out_ready;
endmodule

// ===== hdl/matrix_multiply_core.sv =====
// ---------------------------------------------------------------------------
// matrix_multiply_core
// Query: one multiply-accumulate per element pair through each store's single
// read port, two pipeline stages, then the publish into the output register;
// an out-of-range query skips the reads and goes straight to the publish.
// Loads run back to back while no query is busy; after a query the next beat
// is taken once its result sits in the output register, later while an older
// result stalls. Reset clears control and sets all sizes to 16.
// ---------------------------------------------------------------------------
module matrix_multiply_core #(
	parameter int MAX_DIM = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	mm_cfg_if.sink       cfg,
	mm_in_if.sink        din,
	mm_out_if.source     dout
);
	import mm_pkg::*;

	mm_cmd_t    cmd;
	mm_status_t status;

	// Size registers are plain flops; take a config beat every cycle.
	assign cfg.ready = 1'b1;

	// Sequencer: holds din.ready low from a query's accept until its result
	// sits in the output register.
	mm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Datapath: element stores, the shared multiply-accumulate and the
	// output register that parts the result from the next input beat.
	mm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.command       (din.command),
		.row_index     (din.row_index),
		.col_index     (din.col_index),
		.element_value (din.element_value),
		.out_valid     (dout.valid),
		.out_ready     (dout.ready),
		.dot_value     (dout.dot_value),
		.range_err     (dout.range_err),
		.cmd           (cmd),
		.status        (status)
	);
endmodule

// ===== hdl/mm_checker.sv =====
// ---------------------------------------------------------------------------
// mm_checker
// Port-level checks on the matrix multiply core, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mm_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic [mm_pkg::CMD_W-1:0]         in_command,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic signed [mm_pkg::DOT_W-1:0]  dot_value,
	input logic                             range_err
);
	import mm_pkg::*;

	// A stalled result beat holds.
	`MM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(dot_value) && $stable(range_err), "result beat changed while stalled")

	// An out-of-range result carries a zero sum.
	`MM_ASSERT_SAME(a_oor_zero, clk, arst_n, out_valid && range_err, dot_value == '0, "out-of-range result with nonzero sum")

	// A query keeps the input side busy on the next cycle.
	`MM_ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && in_ready && (in_command == CMD_QUERY), !in_ready, "input ready right after a query")

	// A load never produces a result.
	`MM_ASSERT_NEXT(a_load_silent, clk, arst_n, in_valid && in_ready && (in_command != CMD_QUERY) && !out_valid, !out_valid, "result appeared after a load")

	// A fresh result only comes out of a busy query.
	`MM_ASSERT_SAME(a_result_busy, clk, arst_n, $rose(out_valid), !$past(in_ready), "result without a running query")
endmodule

bind matrix_multiply_core mm_checker u_mm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (din.valid),
	.in_ready   (din.ready),
	.in_command (din.command),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.dot_value  (dout.dot_value),
	.range_err  (dout.range_err)
);
